// ===== rtl/tbar_pkg.sv =====
// ----------------------------------------------------------------------------
// tbar_pkg: shared types and constants of the two-button auto-repeat block.
// Holds the configuration word layout, the register map and the level limits.
// ----------------------------------------------------------------------------
package tbar_pkg;

	localparam int CFG_W = 10;

	typedef logic [CFG_W-1:0] cfg_word_t;
	typedef logic [1:0]       level_t;

	localparam level_t LEVEL_IDLE  = 2'd0;
	localparam level_t LEVEL_FIRST = 2'd1;
	localparam level_t LEVEL_MAX   = 2'd2;

	localparam cfg_word_t INITIAL_DELAY_RST = 10'd20;
	localparam cfg_word_t SECOND_GAP_RST    = 10'd80;
	localparam cfg_word_t REPEAT_GAP_RST    = 10'd20;

	typedef enum logic [1:0] {
		REG_INITIAL_DELAY = 2'd0,
		REG_SECOND_GAP    = 2'd1,
		REG_REPEAT_GAP    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		cfg_word_t initial_delay;
		cfg_word_t second_gap;
		cfg_word_t repeat_gap;
	} cfg_t;

endpackage

// ===== rtl/tbar_channel.sv =====
// ----------------------------------------------------------------------------
// tbar_channel: next-state logic of one button channel.
// Decides click or repeat step, raises or clears the level and moves or reloads the threshold.
// ----------------------------------------------------------------------------
module tbar_channel import tbar_pkg::*; #(
	parameter int HOLD_COUNT_WIDTH = 16,
	parameter int THR_W = (HOLD_COUNT_WIDTH + 1 > CFG_W) ? HOLD_COUNT_WIDTH + 1 : CFG_W
) (
	input  logic [HOLD_COUNT_WIDTH-1:0] held,
	input  logic                        released,
	input  level_t                      level,
	input  logic [THR_W-1:0]            thr,
	input  cfg_t                        cfg,
	output logic                        step,
	output level_t                      level_nxt,
	output logic [THR_W-1:0]            thr_nxt
);

	// Largest threshold reachable by addition: all ones in HOLD_COUNT_WIDTH+1 bits.
	localparam logic [THR_W:0] THR_MAX =
		{{(THR_W - HOLD_COUNT_WIDTH){1'b0}}, {(HOLD_COUNT_WIDTH + 1){1'b1}}};

	level_t           level_up;
	cfg_word_t        gap;
	logic [THR_W:0]   thr_sum;
	logic             hold_hit;

	always_comb begin
		level_up = (level < LEVEL_MAX) ? level + 2'd1 : LEVEL_MAX;
		gap      = (level_up == LEVEL_FIRST) ? cfg.second_gap : cfg.repeat_gap;
		thr_sum  = {1'b0, thr} + {{(THR_W + 1 - CFG_W){1'b0}}, gap};
		hold_hit = (held != '0) &&
			({{(THR_W - HOLD_COUNT_WIDTH){1'b0}}, held} >= thr);
	end

	always_comb begin
		step      = 1'b0;
		level_nxt = level;
		thr_nxt   = thr;
		if (released) begin
			step      = (level == LEVEL_IDLE);
			level_nxt = LEVEL_IDLE;
			thr_nxt   = {{(THR_W - CFG_W){1'b0}}, cfg.initial_delay};
		end else if (hold_hit) begin
			step      = 1'b1;
			level_nxt = level_up;
			thr_nxt   = (thr_sum > THR_MAX) ? THR_MAX[THR_W-1:0] : thr_sum[THR_W-1:0];
		end
	end

endmodule

// ===== rtl/two_button_auto_repeat.sv =====
// ----------------------------------------------------------------------------
// two_button_auto_repeat: an accepted word moves from the input register to the result register
// once that is empty or being read. Throughput is one word per cycle while result_ready is high.
// A stalled result word holds the input register, and item_ready then follows result_ready
// combinationally. Reset clears mode, levels and valids; thresholds and registers take their defaults.
// ----------------------------------------------------------------------------
module two_button_auto_repeat import tbar_pkg::*; #(
	parameter int HOLD_COUNT_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// Input channel
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [HOLD_COUNT_WIDTH-1:0] yes_held_ticks,
	input  logic                        yes_released,
	input  logic [HOLD_COUNT_WIDTH-1:0] no_held_ticks,
	input  logic                        no_released,
	// Result channel
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        yes_step,
	output logic                        no_step,
	output logic                        confirm_pulse
);

	localparam int THR_W = (HOLD_COUNT_WIDTH + 1 > CFG_W) ? HOLD_COUNT_WIDTH + 1 : CFG_W;

	cfg_t cfg_q;
	reg_idx_t reg_idx;
	logic cfg_wr;

	logic                        valid_s1;
	logic [HOLD_COUNT_WIDTH-1:0] yes_held_s1, no_held_s1;
	logic                        yes_rel_s1, no_rel_s1;

	logic             both_mode_q;
	level_t           yes_level_q, no_level_q;
	logic [THR_W-1:0] yes_thr_q, no_thr_q;

	logic result_valid_q, yes_step_q, no_step_q, confirm_q;

	logic             s1_fire;
	logic             yes_ch_step, no_ch_step;
	level_t           yes_ch_level, no_ch_level;
	logic [THR_W-1:0] yes_ch_thr, no_ch_thr;

	logic             both_mode_d, yes_step_d, no_step_d, confirm_d;
	level_t           yes_level_d, no_level_d;
	logic [THR_W-1:0] yes_thr_d, no_thr_d;
	logic             yes_act, no_act;

	// ---------------- configuration registers ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_delay <= INITIAL_DELAY_RST;
			cfg_q.second_gap    <= SECOND_GAP_RST;
			cfg_q.repeat_gap    <= REPEAT_GAP_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_INITIAL_DELAY: cfg_q.initial_delay <= pwdata[CFG_W-1:0];
				REG_SECOND_GAP:    cfg_q.second_gap    <= pwdata[CFG_W-1:0];
				REG_REPEAT_GAP:    cfg_q.repeat_gap    <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_INITIAL_DELAY: prdata = {{(32 - CFG_W){1'b0}}, cfg_q.initial_delay};
			REG_SECOND_GAP:    prdata = {{(32 - CFG_W){1'b0}}, cfg_q.second_gap};
			REG_REPEAT_GAP:    prdata = {{(32 - CFG_W){1'b0}}, cfg_q.repeat_gap};
			default:           prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	assign s1_fire    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			yes_held_s1 <= yes_held_ticks;
			yes_rel_s1  <= yes_released;
			no_held_s1  <= no_held_ticks;
			no_rel_s1   <= no_released;
		end
	end

	// ---------------- per-channel logic ----------------
	tbar_channel #(.HOLD_COUNT_WIDTH(HOLD_COUNT_WIDTH), .THR_W(THR_W)) u_yes (
		.held      (yes_held_s1),
		.released  (yes_rel_s1),
		.level     (yes_level_q),
		.thr       (yes_thr_q),
		.cfg       (cfg_q),
		.step      (yes_ch_step),
		.level_nxt (yes_ch_level),
		.thr_nxt   (yes_ch_thr)
	);

	tbar_channel #(.HOLD_COUNT_WIDTH(HOLD_COUNT_WIDTH), .THR_W(THR_W)) u_no (
		.held      (no_held_s1),
		.released  (no_rel_s1),
		.level     (no_level_q),
		.thr       (no_thr_q),
		.cfg       (cfg_q),
		.step      (no_ch_step),
		.level_nxt (no_ch_level),
		.thr_nxt   (no_ch_thr)
	);

	// A button counts as active while held and on the tick it is released.
	always_comb begin
		yes_act     = (yes_held_s1 != '0) || yes_rel_s1;
		no_act      = (no_held_s1 != '0) || no_rel_s1;
		both_mode_d = both_mode_q;
		yes_level_d = yes_level_q;
		no_level_d  = no_level_q;
		yes_thr_d   = yes_thr_q;
		no_thr_d    = no_thr_q;
		yes_step_d  = 1'b0;
		no_step_d   = 1'b0;
		confirm_d   = 1'b0;
		if (both_mode_q) begin
			if ((yes_held_s1 == '0) && (no_held_s1 == '0)) begin
				both_mode_d = 1'b0;
				yes_level_d = LEVEL_IDLE;
				no_level_d  = LEVEL_IDLE;
				yes_thr_d   = {{(THR_W - CFG_W){1'b0}}, cfg_q.initial_delay};
				no_thr_d    = {{(THR_W - CFG_W){1'b0}}, cfg_q.initial_delay};
			end
		end else if (yes_act && no_act) begin
			// Confirm only when neither button has started repeating.
			if ((yes_level_q == LEVEL_IDLE) && (no_level_q == LEVEL_IDLE)) begin
				both_mode_d = 1'b1;
				confirm_d   = 1'b1;
			end
		end else begin
			yes_step_d  = yes_ch_step;
			no_step_d   = no_ch_step;
			yes_level_d = yes_ch_level;
			no_level_d  = no_ch_level;
			yes_thr_d   = yes_ch_thr;
			no_thr_d    = no_ch_thr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			both_mode_q <= 1'b0;
			yes_level_q <= LEVEL_IDLE;
			no_level_q  <= LEVEL_IDLE;
			yes_thr_q   <= {{(THR_W - CFG_W){1'b0}}, INITIAL_DELAY_RST};
			no_thr_q    <= {{(THR_W - CFG_W){1'b0}}, INITIAL_DELAY_RST};
		end else if (s1_fire) begin
			both_mode_q <= both_mode_d;
			yes_level_q <= yes_level_d;
			no_level_q  <= no_level_d;
			yes_thr_q   <= yes_thr_d;
			no_thr_q    <= no_thr_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			yes_step_q <= yes_step_d;
			no_step_q  <= no_step_d;
			confirm_q  <= confirm_d;
		end
	end

	assign result_valid  = result_valid_q;
	assign yes_step      = yes_step_q;
	assign no_step       = no_step_q;
	assign confirm_pulse = confirm_q;

`ifndef ASSERT_OFF
	// Entering both-mode always goes with a confirm word loaded at the same edge.
	a_enter_confirms: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(both_mode_q) |-> (result_valid_q && confirm_q))
		else $error("both-mode entered without a confirm word");

	// A word computed in both-mode carries no step and no confirm.
	a_both_mode_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && both_mode_q) |=> (!yes_step_q && !no_step_q && !confirm_q))
		else $error("step or confirm produced while in both-mode");

	// A confirm is only given when neither channel had started repeating.
	a_confirm_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && confirm_d) |-> ((yes_level_q == LEVEL_IDLE) && (no_level_q == LEVEL_IDLE)))
		else $error("confirm given with a repeat pending");

	// Levels never leave the range idle to max.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(yes_level_q <= LEVEL_MAX) && (no_level_q <= LEVEL_MAX))
		else $error("channel level out of range");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: two-button auto-repeat with a two-button confirm
// Feeds poll-tick words through the valid/ready input channel and checks every
// result word against its table entry or a local model of the repeat levels,
// thresholds and both-button mode. It covers a directed table and then random
// press sequences under several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench import tbar_pkg::*;;

	localparam int HW          = 16;
	localparam int DIR_ROWS    = 17;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 275;
	localparam logic [HW:0] THR_SAT = '1;

	typedef struct packed {
		logic [HW-1:0] yes_held;
		logic          yes_rel;
		logic [HW-1:0] no_held;
		logic          no_rel;
	} tick_t;

	typedef struct packed {
		logic yes_step;
		logic no_step;
		logic confirm;
	} steps_t;

	typedef struct packed {
		tick_t  t;
		logic   typed;
		steps_t want;
	} dir_row_t;

	logic          clk;
	logic          arst_n;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [3:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;
	logic          item_valid;
	logic          item_ready;
	logic [HW-1:0] yes_held_ticks;
	logic          yes_released;
	logic [HW-1:0] no_held_ticks;
	logic          no_released;
	logic          result_valid;
	logic          result_ready;
	logic          yes_step;
	logic          no_step;
	logic          confirm_pulse;

	// Local copy of the registers and the block state.
	cfg_word_t   delay_cfg;
	cfg_word_t   second_cfg;
	cfg_word_t   repeat_cfg;
	logic        both_latched;
	level_t      yes_lvl;
	level_t      no_lvl;
	logic [HW:0] yes_thr;
	logic [HW:0] no_thr;

	steps_t   pending_steps[$];
	dir_row_t dir_tbl [DIR_ROWS];
	int       mismatches;
	bit       quiet;
	int       yes_cnt;
	int       no_cnt;

	two_button_auto_repeat #(
		.HOLD_COUNT_WIDTH(HW)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.yes_held_ticks(yes_held_ticks),
		.yes_released  (yes_released),
		.no_held_ticks (no_held_ticks),
		.no_released   (no_released),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.yes_step      (yes_step),
		.no_step       (no_step),
		.confirm_pulse (confirm_pulse)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic advance_button(input logic [HW-1:0] held, input logic rel,
			inout level_t lvl, inout logic [HW:0] thr);
		logic          step;
		logic [HW+1:0] sum;
		step = 1'b0;
		if (rel) begin
			// A release clicks only when the button never repeated.
			step = (lvl == LEVEL_IDLE);
			lvl = LEVEL_IDLE;
			thr = {{(HW+1-CFG_W){1'b0}}, delay_cfg};
		end else if (held != '0 && {1'b0, held} >= thr) begin
			if (lvl < LEVEL_MAX)
				lvl = lvl + 2'd1;
			sum = {1'b0, thr} + ((lvl == LEVEL_FIRST) ? second_cfg : repeat_cfg);
			thr = (sum > THR_SAT) ? THR_SAT : sum[HW:0];
			step = 1'b1;
		end
		return step;
	endfunction

	function automatic steps_t predict_tick(input tick_t t);
		steps_t s;
		s = '0;
		if (both_latched) begin
			if (t.yes_held == '0 && t.no_held == '0) begin
				both_latched = 1'b0;
				yes_lvl = LEVEL_IDLE;
				no_lvl = LEVEL_IDLE;
				yes_thr = {{(HW+1-CFG_W){1'b0}}, delay_cfg};
				no_thr = {{(HW+1-CFG_W){1'b0}}, delay_cfg};
			end
		end else if ((t.yes_held != '0 || t.yes_rel) && (t.no_held != '0 || t.no_rel)) begin
			// With a repeat pending on either side, both active does nothing.
			if (yes_lvl == LEVEL_IDLE && no_lvl == LEVEL_IDLE) begin
				both_latched = 1'b1;
				s.confirm = 1'b1;
			end
		end else begin
			s.yes_step = advance_button(t.yes_held, t.yes_rel, yes_lvl, yes_thr);
			s.no_step = advance_button(t.no_held, t.no_rel, no_lvl, no_thr);
		end
		return s;
	endfunction

	function automatic dir_row_t dir_entry(input logic [HW-1:0] yh, input logic yr,
			input logic [HW-1:0] nh, input logic nr, input logic typed,
			input logic ys, input logic ns, input logic cf);
		dir_row_t r;
		r.t = '{yh, yr, nh, nr};
		r.typed = typed;
		r.want = '{ys, ns, cf};
		return r;
	endfunction

	function automatic logic [HW-1:0] noise_count();
		logic [HW-1:0] v;
		case ($urandom_range(0, 3))
			0:       v = '0;
			1:       v = HW'($urandom_range(0, 40));
			2:       v = HW'($urandom);
			default: v = '1;
		endcase
		return v;
	endfunction

	// One button of a realistic press sequence: the count climbs by one per tick,
	// with an occasional jump, and a release reports zero with the flag set.
	task automatic press_button(inout int cnt, input bit allow, output logic [HW-1:0] held,
			output logic rel);
		rel = 1'b0;
		if (cnt == 0) begin
			if (allow && $urandom_range(0, 7) == 0)
				cnt = 1;
		end else if ($urandom_range(0, 39) == 0) begin
			cnt = 0;
			rel = 1'b1;
		end else begin
			cnt += ($urandom_range(0, 29) == 0) ? $urandom_range(1, 1100) : 1;
			if (cnt > 65535)
				cnt = 65535;
		end
		held = HW'(cnt);
	endtask

	task automatic apb_write(input reg_idx_t idx, input cfg_word_t v);
		logic [31:0] data;
		data = $urandom;
		data[CFG_W-1:0] = v;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_INITIAL_DELAY: delay_cfg = v;
			REG_SECOND_GAP:    second_cfg = v;
			REG_REPEAT_GAP:    repeat_cfg = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_registers(input int p);
		cfg_word_t d, s, r;
		case (p)
			0: begin d = INITIAL_DELAY_RST; s = SECOND_GAP_RST; r = REPEAT_GAP_RST; end
			1: begin d = 10'd1; s = 10'd1; r = 10'd1; end
			2: begin d = 10'd1023; s = 10'd1023; r = 10'd1023; end
			3: begin d = 10'd0; s = 10'd1023; r = 10'd1; end
			4: begin
				d = cfg_word_t'($urandom_range(1, 1023));
				s = cfg_word_t'($urandom_range(1, 1023));
				r = cfg_word_t'($urandom_range(1, 1023));
			end
			default: begin d = 10'd3; s = 10'd40; r = 10'd7; end
		endcase
		apb_write(REG_INITIAL_DELAY, d);
		apb_write(REG_SECOND_GAP, s);
		apb_write(REG_REPEAT_GAP, r);
	endtask

	task automatic send_tick(input tick_t t, input logic typed, input steps_t want);
		steps_t predicted;
		item_valid <= 1'b1;
		yes_held_ticks <= t.yes_held;
		yes_released <= t.yes_rel;
		no_held_ticks <= t.no_held;
		no_released <= t.no_rel;
		do @(posedge clk); while (!item_ready);
		predicted = predict_tick(t);
		pending_steps.push_back(typed ? want : predicted);
	endtask

	task automatic idle_sender();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending_steps.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic exp, input logic act);
		if (exp !== act) begin
			mismatches++;
			if (mismatches <= 50)
				$display("%0t ns: %s mismatch, expected %0b, actual %0b", $time, name, exp, act);
		end
	endtask

	// Stimulus.
	initial begin
		tick_t         t;
		logic [HW-1:0] yh, nh;
		logic          yr, nr;
		int            allow;
		int            seg_left;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		yes_held_ticks = '0;
		yes_released = 1'b0;
		no_held_ticks = '0;
		no_released = 1'b0;
		mismatches = 0;
		quiet = 1'b0;
		yes_cnt = 0;
		no_cnt = 0;
		allow = 3;
		seg_left = 0;
		delay_cfg = INITIAL_DELAY_RST;
		second_cfg = SECOND_GAP_RST;
		repeat_cfg = REPEAT_GAP_RST;
		both_latched = 1'b0;
		yes_lvl = LEVEL_IDLE;
		no_lvl = LEVEL_IDLE;
		yes_thr = {{(HW+1-CFG_W){1'b0}}, INITIAL_DELAY_RST};
		no_thr = {{(HW+1-CFG_W){1'b0}}, INITIAL_DELAY_RST};

		dir_tbl = '{
			dir_entry(16'd0,    1'b0, 16'd0,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0),
			dir_entry(16'd1,    1'b0, 16'd0,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0),
			dir_entry(16'd20,   1'b0, 16'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
			dir_entry(16'd100,  1'b0, 16'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
			dir_entry(16'hFFFF, 1'b0, 16'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
			dir_entry(16'd0,    1'b1, 16'd0,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0),
			dir_entry(16'hFFFF, 1'b1, 16'd0,    1'b0, 1'b1, 1'b1, 1'b0, 1'b0),
			dir_entry(16'd0,    1'b0, 16'd20,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
			dir_entry(16'd5,    1'b0, 16'd30,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0),
			dir_entry(16'd0,    1'b0, 16'd0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0),
			dir_entry(16'd3,    1'b0, 16'd3,    1'b0, 1'b1, 1'b0, 1'b0, 1'b1),
			dir_entry(16'd0,    1'b1, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0),
			dir_entry(16'd0,    1'b0, 16'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
			dir_entry(16'd0,    1'b1, 16'd0,    1'b0, 1'b1, 1'b1, 1'b0, 1'b0),
			dir_entry(16'd0,    1'b1, 16'd0,    1'b1, 1'b1, 1'b0, 1'b0, 1'b1),
			dir_entry(16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0),
			dir_entry(16'd0,    1'b0, 16'd0,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words run under the reset register values.
		for (int i = 0; i < DIR_ROWS; i++) begin
			send_tick(dir_tbl[i].t, dir_tbl[i].typed, dir_tbl[i].want);
			if (i != DIR_ROWS - 1)
				idle_sender();
		end
		drain_results();

		for (int p = 0; p < PHASES; p++) begin
			set_registers(p);
			quiet = (p == PHASES - 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (seg_left == 0) begin
					allow = $urandom_range(1, 3);
					seg_left = $urandom_range(20, 60);
				end
				seg_left--;
				if ($urandom_range(0, 5) == 0) begin
					// Noise: counts and release flags that no real button makes.
					t = '{noise_count(), 1'($urandom), noise_count(), 1'($urandom)};
				end else begin
					press_button(yes_cnt, allow[0], yh, yr);
					press_button(no_cnt, allow[1], nh, nr);
					t = '{yh, yr, nh, nr};
				end
				send_tick(t, 1'b0, '0);
				if (i == PHASE_ITEMS - 1)
					;
				else if (p == 1 && i == PHASE_ITEMS / 2)
					drain_results();
				else
					idle_sender();
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Result side: random stalls, none in the last phase.
	initial begin
		int     stall;
		steps_t exp;
		stall = 0;
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) begin
				if (pending_steps.size() == 0) begin
					mismatches++;
					if (mismatches <= 50)
						$display("%0t ns: result word with none expected, actual %0b%0b%0b",
							$time, yes_step, no_step, confirm_pulse);
				end else begin
					exp = pending_steps.pop_front();
					check_field("yes_step", exp.yes_step, yes_step);
					check_field("no_step", exp.no_step, no_step);
					check_field("confirm_pulse", exp.confirm, confirm_pulse);
				end
			end
			if (stall > 0) begin
				stall--;
				result_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 7) - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
